>>> rtl/piddf_pkg.sv
// ----------------------------------------------------------------------------
// piddf_pkg
// Shared types, constants and fixed-point helpers for the PID controller
// with filtered derivative and filtered output.
// ----------------------------------------------------------------------------
package piddf_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_GAIN_P         = 3'd0,
		CFG_GAIN_I_DT      = 3'd1,
		CFG_GAIN_D_PER_DT  = 3'd2,
		CFG_DRIVE_MIN      = 3'd3,
		CFG_DRIVE_MAX      = 3'd4,
		CFG_ACCUM_MIN      = 3'd5,
		CFG_ACCUM_MAX      = 3'd6,
		CFG_FILTER_CONTROL = 3'd7
	} cfg_idx_t;

	// Input command codes
	localparam logic CMD_COMPUTE = 1'b0;
	localparam logic CMD_CLEAR   = 1'b1;

	// Register reset values
	localparam logic signed [31:0] GAIN_RST       = 32'sd0;
	localparam logic signed [31:0] DRIVE_MIN_RST  = 32'sh8000_0000;
	localparam logic signed [31:0] DRIVE_MAX_RST  = 32'sh7FFF_FFFF;
	localparam logic signed [47:0] ACCUM_MIN_RST  = 48'sh8000_0000_0000;
	localparam logic signed [47:0] ACCUM_MAX_RST  = 48'sh7FFF_FFFF_FFFF;
	localparam logic [36:0]        FILTER_CTL_RST = 37'd54116627251;

	// filter_control fields
	localparam int FC_D_ALPHA_LSB   = 0;
	localparam int FC_OUT_ALPHA_LSB = 17;
	localparam int FC_D_ON          = 34;
	localparam int FC_OUT_ON        = 35;
	localparam int FC_D_FROM_MEAS   = 36;

	localparam logic [16:0] ALPHA_MIN = 17'd655;
	localparam logic [16:0] ALPHA_ONE = 17'd65536;

	// Register bundle handed to the datapath
	typedef struct packed {
		logic signed [31:0] gain_p;
		logic signed [31:0] gain_i_dt;
		logic signed [31:0] gain_d_per_dt;
		logic signed [31:0] drive_min;
		logic signed [31:0] drive_max;
		logic signed [47:0] accum_min;
		logic signed [47:0] accum_max;
		logic [36:0]        filter_control;
	} cfg_t;

	// Operand selection for the shared multiplier
	typedef enum logic [2:0] {
		MOP_NONE,
		MOP_P,
		MOP_I_LO,
		MOP_I_HI,
		MOP_D,
		MOP_D_FLT,
		MOP_OUT_FLT
	} mul_op_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_ERR,
		S_ACC,
		S_IL,
		S_IH,
		S_ID,
		S_DRAW,
		S_DFM,
		S_DSUM,
		S_RAW,
		S_OFM,
		S_OFLT,
		S_DONE,
		S_CLR
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    capture;
		logic    calc_err;
		logic    upd_acc;
		logic    ld_p;
		logic    ld_lo;
		logic    ld_i;
		logic    ld_draw;
		logic    ld_dflt;
		logic    ld_raw;
		logic    commit;
		logic    ld_drive;
		logic    clear;
		mul_op_t mul_op;
	} dp_cmd_t;

	// Saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		if (&v[67:31] || ~|v[67:31])
			return v[31:0];
		return v[67] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
	endfunction

	// Round half up at bit 16, then saturate
	function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] p);
		logic signed [67:0] s;
		s = {{2{p[65]}}, p} + 68'sd32768;
		return sat32(s >>> 16);
	endfunction

	// Finish a low-pass: y + a*(x-y), rounded, saturated; p holds a*(x-y)
	function automatic logic signed [31:0] lp_finish(input logic signed [65:0] p,
		input logic signed [31:0] y);
		logic signed [67:0] s;
		s = ({{36{y[31]}}, y} <<< 16) + {{2{p[65]}}, p} + 68'sd32768;
		return sat32(s >>> 16);
	endfunction

	function automatic logic [16:0] alpha_clamp(input logic [16:0] b);
		if (b < ALPHA_MIN)
			return ALPHA_MIN;
		if (b > ALPHA_ONE)
			return ALPHA_ONE;
		return b;
	endfunction

endpackage

>>> rtl/pid_with_derivative_and_output_filter_top.sv
// ----------------------------------------------------------------------------
// pid_with_derivative_and_output_filter_top
// PID controller, signed Q16.16, with trapezoidal integral, low-pass
// derivative and low-pass output stage on one shared 33x33 multiplier.
// A compute item makes six passes through the shared multiplier plus the sums;
// the block takes no new request until the current item is finished.
// A new item is taken while the previous drive waits in the output register.
// Reset (arst_n low, asynchronous) restores register defaults and clears
// controller state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pid_with_derivative_and_output_filter_top (
	input  logic               clk,
	input  logic               arst_n,
	// compute / clear requests
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               command,
	input  logic signed [31:0] target,
	input  logic signed [31:0] measured,
	// drive results
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [31:0] drive,
	// register writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_data
);
	import piddf_pkg::*;

	cfg_t    cfg_q;
	dp_cmd_t cmd;
	logic    rsp_valid_q;
	logic    rsp_load;
	logic    out_free;

	// Register writes must be issued only while idle (the block does not enforce this), so always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p         <= GAIN_RST;
			cfg_q.gain_i_dt      <= GAIN_RST;
			cfg_q.gain_d_per_dt  <= GAIN_RST;
			cfg_q.drive_min      <= DRIVE_MIN_RST;
			cfg_q.drive_max      <= DRIVE_MAX_RST;
			cfg_q.accum_min      <= ACCUM_MIN_RST;
			cfg_q.accum_max      <= ACCUM_MAX_RST;
			cfg_q.filter_control <= FILTER_CTL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GAIN_P:         cfg_q.gain_p         <= cfg_data[31:0];
				CFG_GAIN_I_DT:      cfg_q.gain_i_dt      <= cfg_data[31:0];
				CFG_GAIN_D_PER_DT:  cfg_q.gain_d_per_dt  <= cfg_data[31:0];
				CFG_DRIVE_MIN:      cfg_q.drive_min      <= cfg_data[31:0];
				CFG_DRIVE_MAX:      cfg_q.drive_max      <= cfg_data[31:0];
				CFG_ACCUM_MIN:      cfg_q.accum_min      <= cfg_data;
				CFG_ACCUM_MAX:      cfg_q.accum_max      <= cfg_data;
				CFG_FILTER_CONTROL: cfg_q.filter_control <= cfg_data[36:0];
				default: ;
			endcase
		end
	end

	// Output register is free when empty or being taken this cycle.
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (rsp_load)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	assign rsp_valid = rsp_valid_q;

	piddf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.command   (command),
		.out_free  (out_free),
		.req_stall (req_stall),
		.rsp_load  (rsp_load),
		.cmd       (cmd)
	);

	piddf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.target   (target),
		.measured (measured),
		.drive    (drive)
	);

endmodule

>>> rtl/piddf_mul.sv
// ----------------------------------------------------------------------------
// piddf_mul
// Shared signed 33x33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module piddf_mul (
	input  logic               clk,
	input  logic signed [32:0] op_a,
	input  logic signed [32:0] op_b,
	output logic signed [65:0] product
);
	logic signed [65:0] product_s1;

	always_ff @(posedge clk) begin
		product_s1 <= op_a * op_b;
	end

	assign product = product_s1;

endmodule

>>> rtl/piddf_ctrl.sv
// ----------------------------------------------------------------------------
// piddf_ctrl
// Step sequencer: walks one item through the shared-multiplier datapath.
// ----------------------------------------------------------------------------
module piddf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               command,
	input  logic               out_free,
	output logic               req_stall,
	output logic               rsp_load,
	output piddf_pkg::dp_cmd_t cmd
);
	import piddf_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid)
					state_nxt = (command == CMD_CLEAR) ? S_CLR : S_ERR;
			end
			S_ERR:  state_nxt = S_ACC;
			S_ACC:  state_nxt = S_IL;
			S_IL:   state_nxt = S_IH;
			S_IH:   state_nxt = S_ID;
			S_ID:   state_nxt = S_DRAW;
			S_DRAW: state_nxt = S_DFM;
			S_DFM:  state_nxt = S_DSUM;
			S_DSUM: state_nxt = S_RAW;
			S_RAW:  state_nxt = S_OFM;
			S_OFM:  state_nxt = S_OFLT;
			S_OFLT: state_nxt = S_DONE;
			S_DONE, S_CLR: begin
				if (out_free)
					state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.mul_op = MOP_NONE;
		rsp_load  = 1'b0;
		req_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: cmd.capture = req_valid;
			S_ERR:  cmd.calc_err = 1'b1;
			S_ACC: begin
				cmd.upd_acc = 1'b1;
				cmd.mul_op  = MOP_P;
			end
			S_IL: begin
				cmd.ld_p   = 1'b1;
				cmd.mul_op = MOP_I_LO;
			end
			S_IH: begin
				cmd.ld_lo  = 1'b1;
				cmd.mul_op = MOP_I_HI;
			end
			S_ID: begin
				cmd.ld_i   = 1'b1;
				cmd.mul_op = MOP_D;
			end
			S_DRAW: cmd.ld_draw = 1'b1;
			S_DFM:  cmd.mul_op = MOP_D_FLT;
			S_DSUM: cmd.ld_dflt = 1'b1;
			S_RAW:  cmd.ld_raw = 1'b1;
			S_OFM:  cmd.mul_op = MOP_OUT_FLT;
			S_OFLT: cmd.commit = 1'b1;
			S_DONE: begin
				cmd.ld_drive = out_free;
				rsp_load     = out_free;
			end
			S_CLR: begin
				cmd.clear    = out_free;
				cmd.ld_drive = out_free;
				rsp_load     = out_free;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/piddf_dp.sv
// ----------------------------------------------------------------------------
// piddf_dp
// Datapath: error, trapezoidal integral, derivative, both low-pass filters,
// controller state and the output holding register.
// ----------------------------------------------------------------------------
module piddf_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  piddf_pkg::cfg_t    cfg,
	input  piddf_pkg::dp_cmd_t cmd,
	input  logic signed [31:0] target,
	input  logic signed [31:0] measured,
	output logic signed [31:0] drive
);
	import piddf_pkg::*;

	// item payload and intermediate terms
	logic signed [31:0] tgt_q, meas_q, error_q;
	logic signed [31:0] p_q, i_q, draw_q, raw_q, drive_q;
	logic signed [48:0] lo_q;

	// controller state
	logic signed [47:0] accum_q;
	logic signed [31:0] last_err_q, last_meas_q, last_d_q, last_out_q;
	logic               first_q;

	logic signed [32:0] op_a, op_b;
	logic signed [65:0] product;

	logic signed [32:0] err_diff, half_sum, d_diff;
	logic signed [48:0] acc_sum, acc_lo_clamp;
	logic signed [48:0] lo_rnd;
	logic signed [67:0] i_full, raw_sum;
	logic [16:0]        alpha_d, alpha_o;
	logic signed [31:0] dflt, oflt, drive_clamp;
	logic               d_on, out_on, d_from_meas;

	assign d_on        = cfg.filter_control[FC_D_ON];
	assign out_on      = cfg.filter_control[FC_OUT_ON];
	assign d_from_meas = cfg.filter_control[FC_D_FROM_MEAS];
	assign alpha_d = alpha_clamp(cfg.filter_control[FC_D_ALPHA_LSB +: 17]);
	assign alpha_o = alpha_clamp(cfg.filter_control[FC_OUT_ALPHA_LSB +: 17]);

	// error and trapezoidal accumulator
	assign err_diff = {tgt_q[31], tgt_q} - {meas_q[31], meas_q};
	assign half_sum = $signed({error_q[31], error_q} + {last_err_q[31], last_err_q}) >>> 1;
	assign acc_sum  = {accum_q[47], accum_q} + {{16{half_sum[32]}}, half_sum};

	always_comb begin
		acc_lo_clamp = acc_sum;
		if (acc_lo_clamp < $signed({cfg.accum_min[47], cfg.accum_min}))
			acc_lo_clamp = $signed({cfg.accum_min[47], cfg.accum_min});
		if (acc_lo_clamp > $signed({cfg.accum_max[47], cfg.accum_max}))
			acc_lo_clamp = $signed({cfg.accum_max[47], cfg.accum_max});
	end

	// derivative source, before the state update
	assign d_diff = d_from_meas ? ({last_meas_q[31], last_meas_q} - {meas_q[31], meas_q})
	                            : ({error_q[31], error_q} - {last_err_q[31], last_err_q});

	// operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.mul_op)
			MOP_P: begin
				op_a = {error_q[31], error_q};
				op_b = {cfg.gain_p[31], cfg.gain_p};
			end
			MOP_I_LO: begin
				op_a = {17'd0, accum_q[15:0]};
				op_b = {cfg.gain_i_dt[31], cfg.gain_i_dt};
			end
			MOP_I_HI: begin
				op_a = {accum_q[47], accum_q[47:16]};
				op_b = {cfg.gain_i_dt[31], cfg.gain_i_dt};
			end
			MOP_D: begin
				op_a = d_diff;
				op_b = {cfg.gain_d_per_dt[31], cfg.gain_d_per_dt};
			end
			MOP_D_FLT: begin
				op_a = {16'd0, alpha_d};
				op_b = {draw_q[31], draw_q} - {last_d_q[31], last_d_q};
			end
			MOP_OUT_FLT: begin
				op_a = {16'd0, alpha_o};
				op_b = {raw_q[31], raw_q} - {last_out_q[31], last_out_q};
			end
			default: ;
		endcase
	end

	piddf_mul u_mul (
		.clk     (clk),
		.op_a    (op_a),
		.op_b    (op_b),
		.product (product)
	);

	// integral: high partial product plus rounded low partial product
	assign lo_rnd = (lo_q + 49'sd32768) >>> 16;
	assign i_full = {{2{product[65]}}, product} + {{35{lo_rnd[32]}}, lo_rnd[32:0]};

	assign dflt    = d_on ? lp_finish(product, last_d_q) : draw_q;
	assign raw_sum = {{36{p_q[31]}}, p_q} + {{36{i_q[31]}}, i_q}
	               + {{36{last_d_q[31]}}, last_d_q};
	assign oflt    = (out_on && !first_q) ? lp_finish(product, last_out_q) : raw_q;

	// output clamp; an inverted pair yields the maximum
	always_comb begin
		drive_clamp = last_out_q;
		if (drive_clamp < cfg.drive_min)
			drive_clamp = cfg.drive_min;
		if (drive_clamp > cfg.drive_max)
			drive_clamp = cfg.drive_max;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tgt_q  <= target;
			meas_q <= measured;
		end
		if (cmd.calc_err)
			error_q <= sat32({{35{err_diff[32]}}, err_diff});
		if (cmd.ld_p)
			p_q <= rnd_sat(product);
		if (cmd.ld_lo)
			lo_q <= product[48:0];
		if (cmd.ld_i)
			i_q <= sat32(i_full);
		if (cmd.ld_draw)
			draw_q <= first_q ? 32'sd0 : rnd_sat(product);
		if (cmd.ld_raw)
			raw_q <= sat32(raw_sum);
		if (cmd.ld_drive)
			drive_q <= cmd.clear ? 32'sd0 : drive_clamp;
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q     <= '0;
			last_err_q  <= '0;
			last_meas_q <= '0;
			last_d_q    <= '0;
			last_out_q  <= '0;
			first_q     <= 1'b1;
		end else if (cmd.clear) begin
			accum_q     <= '0;
			last_err_q  <= '0;
			last_meas_q <= '0;
			last_d_q    <= '0;
			last_out_q  <= '0;
			first_q     <= 1'b1;
		end else begin
			if (cmd.upd_acc)
				accum_q <= acc_lo_clamp[47:0];
			if (cmd.ld_dflt)
				last_d_q <= dflt;
			if (cmd.commit) begin
				last_out_q <= oflt;
				last_err_q <= error_q;
				first_q    <= 1'b0;
				if (d_from_meas)
					last_meas_q <= meas_q;
			end
		end
	end

	assign drive = drive_q;

endmodule
